>>> rtl/bxavg_pkg.sv
package bxavg_pkg;

  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 13;
  localparam int HEIGHT_W   = 16;
  localparam int SCALE_W    = 5;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_SCALE_DEF = 16;

  localparam int PIX_MAX        = 255;
  localparam int SCALE_MAX_CODE = (1 << SCALE_W) - 1;

  // (r+g+b)/3 as a multiply and shift, exact for sums below 2048
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_SCALE_FACTOR = 2'd2,
    REG_MONO_MODE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_or_gray;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] average_value;
    logic             end_of_row;
    logic             end_of_image;
  } pix_out_t;

  typedef struct packed {
    logic                busy;
    logic                mono_mode;
    logic [WIDTH_W-1:0]  width_eff;
    logic [HEIGHT_W-1:0] height_eff;
    logic [SCALE_W-1:0]  scale_eff;
    logic [WIDTH_W-1:0]  blocks_x;
    logic [HEIGHT_W-1:0] rows_used;
  } geom_t;

  // largest scale the register can actually reach
  function automatic int scale_cap(int max_scale);
    return (max_scale < SCALE_MAX_CODE) ? max_scale : SCALE_MAX_CODE;
  endfunction

  function automatic int sum_width(int max_scale);
    int c;
    c = scale_cap(max_scale);
    return $clog2(PIX_MAX * c * c + 1);
  endfunction

  // shift of the reciprocal multiply: sum bits plus bits of scale squared
  function automatic int rcp_shift(int max_scale);
    int c;
    c = scale_cap(max_scale);
    return sum_width(max_scale) + $clog2(c * c);
  endfunction

  function automatic int sq_width(int max_scale);
    int c;
    c = scale_cap(max_scale);
    return $clog2(c * c + 1);
  endfunction

endpackage

>>> rtl/bxavg_ram.sv
module bxavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bxavg_div.sv
module bxavg_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // restoring divide, one quotient bit a cycle, dividend shifts out the top
  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIVIDEND_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
      rem_r <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/bxavg_cfg.sv
module bxavg_cfg #(
  parameter int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = bxavg_pkg::MAX_SCALE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bxavg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output bxavg_pkg::geom_t                     geom,
  output logic [bxavg_pkg::rcp_shift(MAX_SCALE):0] recip
);

  localparam int K      = bxavg_pkg::rcp_shift(MAX_SCALE);
  localparam int RCP_W  = K + 1;
  localparam int DIV_W  = (K > bxavg_pkg::HEIGHT_W) ? K : bxavg_pkg::HEIGHT_W;
  localparam int DVS_W  = bxavg_pkg::sq_width(MAX_SCALE);
  localparam int WW     = bxavg_pkg::WIDTH_W;
  localparam int HW     = bxavg_pkg::HEIGHT_W;
  localparam int SW     = bxavg_pkg::SCALE_W;
  localparam logic [DIV_W-1:0] RCP_NUM = DIV_W'({K{1'b1}});

  typedef enum logic [5:0] {
    CS_IDLE = 6'b000001,
    CS_PREP = 6'b000010,
    CS_DIVW = 6'b000100,
    CS_DIVH = 6'b001000,
    CS_MULH = 6'b010000,
    CS_DIVR = 6'b100000
  } cs_t;

  logic [WW-1:0]    image_width_r;
  logic [HW-1:0]    image_height_r;
  logic [SW-1:0]    scale_factor_r;
  logic             mono_mode_r;

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [SW-1:0]    s_eff;
  logic [2*SW-1:0]  sq_full;
  logic [HW+SW-1:0] rows_full;

  cs_t              cs_r, cs_nxt;
  logic [DVS_W-1:0] sq_r;
  logic [WW-1:0]    blocks_x_r;
  logic [HW-1:0]    hq_r;
  logic [HW-1:0]    rows_used_r;
  logic [RCP_W-1:0] recip_r;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quotient;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WW'(1);
      image_height_r <= HW'(1);
      scale_factor_r <= SW'(1);
      mono_mode_r    <= 1'b0;
    end else if (cfg_we) begin
      case (bxavg_pkg::cfg_reg_t'(cfg_index))
        bxavg_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[WW-1:0];
        bxavg_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[HW-1:0];
        bxavg_pkg::REG_SCALE_FACTOR: scale_factor_r <= cfg_wdata[SW-1:0];
        bxavg_pkg::REG_MONO_MODE:    mono_mode_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // out-of-range register values fold back to the nearest legal one
  always_comb begin
    if (image_width_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(image_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = image_width_r;
    end
    h_eff = (image_height_r == '0) ? HW'(1) : image_height_r;
    if (scale_factor_r == '0) begin
      s_eff = SW'(1);
    end else if (int'(scale_factor_r) > MAX_SCALE) begin
      s_eff = SW'(MAX_SCALE);
    end else begin
      s_eff = scale_factor_r;
    end
    sq_full   = (2*SW)'(s_eff) * (2*SW)'(s_eff);
    rows_full = (HW+SW)'(hq_r) * (HW+SW)'(s_eff);
  end

  // after any write: width/scale, height/scale, rows used, then 2^K / scale^2 rounded up
  always_comb begin
    cs_nxt       = cs_r;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (cs_r)
      CS_IDLE: ;
      CS_PREP: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(w_eff);
        div_divisor  = DVS_W'(s_eff);
        cs_nxt       = CS_DIVW;
      end
      CS_DIVW: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(h_eff);
          div_divisor  = DVS_W'(s_eff);
          cs_nxt       = CS_DIVH;
        end
      end
      CS_DIVH: begin
        if (div_done) begin
          cs_nxt = CS_MULH;
        end
      end
      CS_MULH: begin
        div_start    = 1'b1;
        div_dividend = RCP_NUM;
        div_divisor  = sq_r;
        cs_nxt       = CS_DIVR;
      end
      CS_DIVR: begin
        if (div_done) begin
          cs_nxt = CS_IDLE;
        end
      end
      default: cs_nxt = CS_IDLE;
    endcase
    if (cfg_we) begin
      cs_nxt = CS_PREP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r        <= CS_IDLE;
      blocks_x_r  <= WW'(1);
      rows_used_r <= HW'(1);
      recip_r     <= RCP_W'(1) << K;
    end else begin
      cs_r <= cs_nxt;
      if (cs_r == CS_DIVW && div_done) begin
        blocks_x_r <= div_quotient[WW-1:0];
      end
      if (cs_r == CS_MULH) begin
        rows_used_r <= rows_full[HW-1:0];
      end
      if (cs_r == CS_DIVR && div_done) begin
        recip_r <= {1'b0, div_quotient[K-1:0]} + RCP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cs_r == CS_PREP) begin
      sq_r <= DVS_W'(sq_full);
    end
    if (cs_r == CS_DIVH && div_done) begin
      hq_r <= div_quotient[HW-1:0];
    end
  end

  bxavg_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    geom.busy       = (cs_r != CS_IDLE) || cfg_we;
    geom.mono_mode  = mono_mode_r;
    geom.width_eff  = w_eff;
    geom.height_eff = h_eff;
    geom.scale_eff  = s_eff;
    geom.blocks_x   = blocks_x_r;
    geom.rows_used  = rows_used_r;
  end

  assign recip = recip_r;

endmodule

>>> rtl/box_average_downscaler.sv
// Channel  Ports                               Item
// in       in_valid  / in_ready  / in_data     one pixel, raster order
// out      out_valid / out_ready / out_data    one block average with row/image marks
// cfg      cfg_we / cfg_index / cfg_wdata      register write, taken at once
//
// Each pixel is taken in ST_IDLE, which reads its block-column sum from the row RAM,
// then added and written back in ST_UPD; in_ready stays low until ST_UPD is left.
// A block average then passes the sum register, the product register (multiply by
// reciprocal) and the output register on its way to out_valid. A register write
// holds in_ready low while the shared serial divider works out blocks per row, rows
// used and the reciprocal 2^K / scale squared (K = 24 at default scale limit).
// rst_n is synchronous: counters and valids clear, registers go to width 1,
// height 1, scale 1, color. The row RAM is not cleared: the first pixel of
// each block overwrites its entry. A stalled output stays in the output
// register; one more result can wait in the product stage behind it.
module box_average_downscaler #(
  parameter int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE = bxavg_pkg::MAX_SCALE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bxavg_pkg::pix_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bxavg_pkg::pix_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [bxavg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bxavg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int K      = bxavg_pkg::rcp_shift(MAX_SCALE);
  localparam int RCP_W  = K + 1;
  localparam int SUM_W  = bxavg_pkg::sum_width(MAX_SCALE);
  localparam int PROD_W = SUM_W + RCP_W;
  localparam int OC_W   = $clog2(MAX_WIDTH + 1);
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WW     = bxavg_pkg::WIDTH_W;
  localparam int HW     = bxavg_pkg::HEIGHT_W;
  localparam int SW     = bxavg_pkg::SCALE_W;
  localparam int PW     = bxavg_pkg::PIX_W;
  localparam int XW     = (OC_W > WW) ? OC_W : WW;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } st_t;

  bxavg_pkg::geom_t    geom;
  logic [RCP_W-1:0]    recip;

  st_t                 st_r, st_nxt;
  logic [WW-1:0]       pc_r, pc_nxt;
  logic [HW-1:0]       pr_r, pr_nxt;
  logic [SW-1:0]       cib_r, cib_nxt;
  logic [SW-1:0]       rib_r, rib_nxt;
  logic [OC_W-1:0]     oc_r, oc_nxt;

  logic [SW:0]         cib_inc, rib_inc;
  logic [WW:0]         pc_inc;
  logic [HW:0]         pr_inc;
  logic [OC_W:0]       oc_inc, oc_wide;

  logic                in_fire;
  logic [9:0]          gray_sum;
  logic [19:0]         gray_prod;
  logic [PW-1:0]       gray;
  logic                act, first, last, eor, eoi;

  logic [PW-1:0]       v_r;
  logic                act_r, first_r, last_r, eor_r, eoi_r;
  logic [AW-1:0]       addr_r;

  logic                ram_re, ram_we;
  logic [SUM_W-1:0]    ram_rdata;
  logic [SUM_W-1:0]    sum_calc;
  logic                can_go;

  logic                sum_v_r, sum_eor_r, sum_eoi_r;
  logic [SUM_W-1:0]    sum_r;
  logic                sum_load, sum_adv;
  logic                prod_v_r, prod_eor_r, prod_eoi_r;
  logic [PROD_W-1:0]   prod_r;
  logic                prod_adv;
  logic                out_valid_r;
  bxavg_pkg::pix_out_t out_data_r;

  bxavg_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .recip     (recip)
  );

  assign in_ready = (st_r == ST_IDLE) && !geom.busy;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    gray_sum  = 10'(in_data.red_or_gray) + 10'(in_data.green) + 10'(in_data.blue);
    gray_prod = 20'(gray_sum) * 20'(bxavg_pkg::DIV3_MUL);
    gray      = geom.mono_mode ? in_data.red_or_gray
                               : gray_prod[bxavg_pkg::DIV3_SHIFT +: PW];
  end

  // position flags and raster counter advance for the pixel at the input
  always_comb begin
    cib_inc = {1'b0, cib_r} + (SW+1)'(1);
    rib_inc = {1'b0, rib_r} + (SW+1)'(1);
    pc_inc  = {1'b0, pc_r} + (WW+1)'(1);
    pr_inc  = {1'b0, pr_r} + (HW+1)'(1);
    oc_inc  = {1'b0, oc_r} + (OC_W+1)'(1);

    act   = (XW'(oc_r) < XW'(geom.blocks_x)) && (pr_r < geom.rows_used);
    first = (rib_r == '0) && (cib_r == '0);
    last  = (rib_inc >= {1'b0, geom.scale_eff}) && (cib_inc >= {1'b0, geom.scale_eff});
    eor   = ((XW+1)'(oc_r) + (XW+1)'(1)) == (XW+1)'(geom.blocks_x);
    eoi   = eor && (pr_inc == {1'b0, geom.rows_used});

    cib_nxt = cib_inc[SW-1:0];
    oc_wide = {1'b0, oc_r};
    rib_nxt = rib_r;
    pr_nxt  = pr_r;
    pc_nxt  = pc_inc[WW-1:0];
    if (cib_inc >= {1'b0, geom.scale_eff}) begin
      cib_nxt = '0;
      oc_wide = oc_inc;
    end
    if (pc_inc >= {1'b0, geom.width_eff}) begin
      pc_nxt  = '0;
      cib_nxt = '0;
      oc_wide = '0;
      rib_nxt = (rib_inc >= {1'b0, geom.scale_eff}) ? '0 : rib_inc[SW-1:0];
      pr_nxt  = pr_inc[HW-1:0];
      if (pr_inc >= {1'b0, geom.height_eff}) begin
        pr_nxt  = '0;
        rib_nxt = '0;
      end
    end
    if (oc_wide > (OC_W+1)'(MAX_WIDTH)) begin
      oc_wide = (OC_W+1)'(MAX_WIDTH);
    end
    oc_nxt = oc_wide[OC_W-1:0];
  end

  assign ram_re = in_fire && act;

  // pipeline toward the output register
  always_comb begin
    prod_adv = prod_v_r && (!out_valid_r || out_ready);
    sum_adv  = sum_v_r && (!prod_v_r || prod_adv);
    can_go   = !(act_r && last_r) || !sum_v_r || sum_adv;
    sum_calc = first_r ? SUM_W'(v_r) : ram_rdata + SUM_W'(v_r);
    ram_we   = (st_r == ST_UPD) && act_r && can_go;
    sum_load = ram_we && last_r;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          st_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // a completed block waits here while the sum stage is full
        if (can_go) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pc_r        <= '0;
      pr_r        <= '0;
      cib_r       <= '0;
      rib_r       <= '0;
      oc_r        <= '0;
      sum_v_r     <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_fire) begin
        pc_r  <= pc_nxt;
        pr_r  <= pr_nxt;
        cib_r <= cib_nxt;
        rib_r <= rib_nxt;
        oc_r  <= oc_nxt;
      end
      sum_v_r     <= sum_load || (sum_v_r && !sum_adv);
      prod_v_r    <= sum_adv || (prod_v_r && !prod_adv);
      out_valid_r <= prod_adv || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      v_r     <= gray;
      act_r   <= act;
      first_r <= first;
      last_r  <= last;
      eor_r   <= eor;
      eoi_r   <= eoi;
      addr_r  <= oc_r[AW-1:0];
    end
    if (sum_load) begin
      sum_r     <= sum_calc;
      sum_eor_r <= eor_r;
      sum_eoi_r <= eoi_r;
    end
    if (sum_adv) begin
      prod_r     <= PROD_W'(sum_r) * PROD_W'(recip);
      prod_eor_r <= sum_eor_r;
      prod_eoi_r <= sum_eoi_r;
    end
    if (prod_adv) begin
      out_data_r.average_value <= prod_r[K +: PW];
      out_data_r.end_of_row    <= prod_eor_r;
      out_data_r.end_of_image  <= prod_eoi_r;
    end
  end

  bxavg_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (sum_calc),
    .re    (ram_re),
    .raddr (oc_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_fire_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (st_r == ST_UPD))
    else $error("accepted item did not reach the update cycle");

  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_v_r && !sum_adv) |=> (sum_v_r && $stable(sum_r)))
    else $error("blocked block sum was lost or changed");

  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_v_r && out_valid_r && !out_ready) |=> (prod_v_r && $stable(prod_r)))
    else $error("waiting product was lost or changed");

  a_eoi_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.end_of_image || out_data_r.end_of_row))
    else $error("end of image without end of row");

  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> ({1'b0, oc_r} < (OC_W+1)'(MAX_WIDTH)))
    else $error("row RAM read beyond its depth");

endmodule
